// ----- rtl/sorted_table_assert.svh -----
// Assertion macros for the checker file of the sorted table.
`ifndef SORTED_TABLE_ASSERT_SVH
`define SORTED_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ST_ASSERT_NOW(LBL, ANT, CON, MSG) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANT) |-> (CON)) \
    else $error(MSG);

// The consequent must hold in the cycle after the antecedent.
`define ST_ASSERT_NEXT(LBL, ANT, CON, MSG) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANT) |=> (CON)) \
    else $error(MSG);

`endif

// ----- rtl/srt_tbl_pkg.sv -----
package srt_tbl_pkg;

  localparam int OP_W    = 3;
  localparam int VAL_W   = 32;
  localparam int SLOT_W  = 7;
  localparam int COUNT_W = 7;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE_VAL = 3'd1,
    OP_REMOVE_AT  = 3'd2,
    OP_READ       = 3'd3,
    OP_FIND       = 3'd4
  } op_t;

  // Read address selection for the table memory.
  typedef enum logic [2:0] {
    RS_LO  = 3'd0,
    RS_MID = 3'd1,
    RS_POS = 3'd2,
    RS_PM1 = 3'd3,
    RS_PM2 = 3'd4,
    RS_PP1 = 3'd5,
    RS_PP2 = 3'd6
  } rsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SRCH,
    S_SCMP,
    S_EVAL,
    S_READ,
    S_IPRIME,
    S_ISHIFT,
    S_IWRITE,
    S_DPRIME,
    S_DSHIFT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic  load;
    rsel_t rsel;
    logic  srch_upd;
    logic  lo_from_pos;
    logic  p_from_fill;
    logic  p_from_lo;
    logic  shift_up;
    logic  shift_down;
    logic  wr_new;
    logic  fill_dec;
    logic  set_ok;
    logic  set_find;
    logic  set_read;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ins_room;
    logic            pos_ok;
    logic            srch_open;
    logic            hit;
    logic            p_eq_lo;
    logic            pm1_eq_lo;
    logic            pp1_end;
    logic            pp2_end;
    logic            out_free;
  } sts_t;

endpackage

// ----- rtl/srt_tbl_ram.sv -----
module srt_tbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/srt_tbl_dp.sv -----
module srt_tbl_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [srt_tbl_pkg::OP_W-1:0]        in_op,
  input  logic [srt_tbl_pkg::VAL_W-1:0]       in_item_value,
  input  logic [srt_tbl_pkg::SLOT_W-1:0]      in_slot_index,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                out_ok,
  output logic [srt_tbl_pkg::VAL_W-1:0]       out_read_value,
  output logic                                out_found,
  output logic [srt_tbl_pkg::COUNT_W-1:0]     out_found_position,
  output logic [srt_tbl_pkg::COUNT_W-1:0]     out_entry_count,
  input  srt_tbl_pkg::cmd_t                   cmd,
  output srt_tbl_pkg::sts_t                   sts
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (CW + 1 > srt_tbl_pkg::COUNT_W) ? CW + 1 : srt_tbl_pkg::COUNT_W;

  logic [srt_tbl_pkg::OP_W-1:0]    op_r;
  logic [srt_tbl_pkg::VAL_W-1:0]   val_r;
  logic [srt_tbl_pkg::SLOT_W-1:0]  pos_r;
  logic [CW-1:0]                   fill_r, fill_nxt;
  logic [CW-1:0]                   lo_r, lo_nxt;
  logic [CW-1:0]                   hi_r, hi_nxt;
  logic [CW-1:0]                   p_r, p_nxt;
  logic                            res_ok_r;
  logic [srt_tbl_pkg::VAL_W-1:0]   res_rd_r;
  logic                            res_fnd_r;
  logic [srt_tbl_pkg::COUNT_W-1:0] res_fpos_r;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_ok_r;
  logic [srt_tbl_pkg::VAL_W-1:0]   out_rd_r;
  logic                            out_fnd_r;
  logic [srt_tbl_pkg::COUNT_W-1:0] out_fpos_r;
  logic [srt_tbl_pkg::COUNT_W-1:0] out_cnt_r;

  logic [CW:0]                     mid_sum;
  logic [CW-1:0]                   mid;
  logic [XW-1:0]                   pos_x, fill_x, pos_m1, fpos_sum;
  logic [CW-1:0]                   p_m1, p_m2;
  logic [CW:0]                     p_p1, p_p2;
  logic                            less;
  logic                            we;
  logic [AW-1:0]                   waddr, raddr;
  logic [srt_tbl_pkg::VAL_W-1:0]   wdata, rdata;

  srt_tbl_ram #(
    .WIDTH(srt_tbl_pkg::VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[CW:1];
  assign pos_x    = XW'(pos_r);
  assign fill_x   = XW'(fill_r);
  assign pos_m1   = pos_x - XW'(1);
  assign fpos_sum = XW'(lo_r) + XW'(1);
  assign p_m1     = p_r - CW'(1);
  assign p_m2     = p_r - CW'(2);
  assign p_p1     = {1'b0, p_r} + (CW+1)'(1);
  assign p_p2     = {1'b0, p_r} + (CW+1)'(2);
  assign less     = rdata < val_r;

  always_comb begin
    case (cmd.rsel)
      srt_tbl_pkg::RS_LO:  raddr = lo_r[AW-1:0];
      srt_tbl_pkg::RS_MID: raddr = mid[AW-1:0];
      srt_tbl_pkg::RS_POS: raddr = pos_m1[AW-1:0];
      srt_tbl_pkg::RS_PM1: raddr = p_m1[AW-1:0];
      srt_tbl_pkg::RS_PM2: raddr = p_m2[AW-1:0];
      srt_tbl_pkg::RS_PP1: raddr = p_p1[AW-1:0];
      srt_tbl_pkg::RS_PP2: raddr = p_p2[AW-1:0];
      default:             raddr = lo_r[AW-1:0];
    endcase
  end

  // A shift step moves the word just read into the slot the pointer names.
  assign we    = cmd.shift_up || cmd.shift_down || cmd.wr_new;
  assign waddr = cmd.wr_new ? lo_r[AW-1:0] : p_r[AW-1:0];
  assign wdata = cmd.wr_new ? val_r : rdata;

  always_comb begin
    sts.op        = op_r;
    sts.ins_room  = fill_r < CW'(CAPACITY);
    sts.pos_ok    = (pos_r != '0) && (pos_x <= fill_x);
    sts.srch_open = lo_r < hi_r;
    sts.hit       = (lo_r < fill_r) && (rdata == val_r);
    sts.p_eq_lo   = p_r == lo_r;
    sts.pm1_eq_lo = p_m1 == lo_r;
    sts.pp1_end   = p_p1 >= {1'b0, fill_r};
    sts.pp2_end   = p_p2 >= {1'b0, fill_r};
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.load) begin
      lo_nxt = '0;
      hi_nxt = fill_r;
    end else if (cmd.srch_upd) begin
      if (less) begin
        lo_nxt = mid + CW'(1);
      end else begin
        hi_nxt = mid;
      end
    end else if (cmd.lo_from_pos) begin
      lo_nxt = pos_m1[CW-1:0];
    end
  end

  always_comb begin
    p_nxt = p_r;
    if (cmd.lo_from_pos) begin
      p_nxt = pos_m1[CW-1:0];
    end else if (cmd.p_from_fill) begin
      p_nxt = fill_r;
    end else if (cmd.p_from_lo) begin
      p_nxt = lo_r;
    end else if (cmd.shift_up) begin
      p_nxt = p_m1;
    end else if (cmd.shift_down) begin
      p_nxt = p_p1[CW-1:0];
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.wr_new) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    p_r  <= p_nxt;
    if (cmd.load) begin
      op_r       <= in_op;
      val_r      <= in_item_value;
      pos_r      <= in_slot_index;
      res_ok_r   <= 1'b0;
      res_rd_r   <= '0;
      res_fnd_r  <= 1'b0;
      res_fpos_r <= '0;
    end else begin
      if (cmd.set_ok || cmd.set_find || cmd.set_read) begin
        res_ok_r <= 1'b1;
      end
      if (cmd.set_find) begin
        res_fnd_r  <= sts.hit;
        res_fpos_r <= fpos_sum[srt_tbl_pkg::COUNT_W-1:0];
      end
      if (cmd.set_read) begin
        res_rd_r <= rdata;
      end
    end
    if (cmd.out_load) begin
      out_ok_r   <= res_ok_r;
      out_rd_r   <= res_rd_r;
      out_fnd_r  <= res_fnd_r;
      out_fpos_r <= res_fpos_r;
      out_cnt_r  <= fill_x[srt_tbl_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_read_value     = out_rd_r;
  assign out_found          = out_fnd_r;
  assign out_found_position = out_fpos_r;
  assign out_entry_count    = out_cnt_r;

endmodule

// ----- rtl/srt_tbl_ctrl.sv -----
module srt_tbl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  srt_tbl_pkg::sts_t sts,
  output srt_tbl_pkg::cmd_t cmd
);

  srt_tbl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srt_tbl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srt_tbl_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = srt_tbl_pkg::S_DISP;
        end
      end
      srt_tbl_pkg::S_DISP: begin
        case (sts.op)
          srt_tbl_pkg::OP_INSERT:
            state_nxt = sts.ins_room ? srt_tbl_pkg::S_SRCH : srt_tbl_pkg::S_RESP;
          srt_tbl_pkg::OP_REMOVE_VAL,
          srt_tbl_pkg::OP_FIND:
            state_nxt = srt_tbl_pkg::S_SRCH;
          srt_tbl_pkg::OP_REMOVE_AT:
            state_nxt = sts.pos_ok ? srt_tbl_pkg::S_DPRIME : srt_tbl_pkg::S_RESP;
          srt_tbl_pkg::OP_READ:
            state_nxt = sts.pos_ok ? srt_tbl_pkg::S_READ : srt_tbl_pkg::S_RESP;
          default:
            state_nxt = srt_tbl_pkg::S_RESP;
        endcase
      end
      srt_tbl_pkg::S_SRCH: begin
        state_nxt = sts.srch_open ? srt_tbl_pkg::S_SCMP : srt_tbl_pkg::S_EVAL;
      end
      srt_tbl_pkg::S_SCMP: begin
        state_nxt = srt_tbl_pkg::S_SRCH;
      end
      srt_tbl_pkg::S_EVAL: begin
        case (sts.op)
          srt_tbl_pkg::OP_INSERT:
            state_nxt = srt_tbl_pkg::S_IPRIME;
          srt_tbl_pkg::OP_REMOVE_VAL:
            state_nxt = sts.hit ? srt_tbl_pkg::S_DPRIME : srt_tbl_pkg::S_RESP;
          default:
            state_nxt = srt_tbl_pkg::S_RESP;
        endcase
      end
      srt_tbl_pkg::S_READ: begin
        state_nxt = srt_tbl_pkg::S_RESP;
      end
      srt_tbl_pkg::S_IPRIME: begin
        state_nxt = sts.p_eq_lo ? srt_tbl_pkg::S_IWRITE : srt_tbl_pkg::S_ISHIFT;
      end
      srt_tbl_pkg::S_ISHIFT: begin
        if (sts.pm1_eq_lo) begin
          state_nxt = srt_tbl_pkg::S_IWRITE;
        end
      end
      srt_tbl_pkg::S_IWRITE: begin
        state_nxt = srt_tbl_pkg::S_RESP;
      end
      srt_tbl_pkg::S_DPRIME: begin
        state_nxt = sts.pp1_end ? srt_tbl_pkg::S_RESP : srt_tbl_pkg::S_DSHIFT;
      end
      srt_tbl_pkg::S_DSHIFT: begin
        if (sts.pp2_end) begin
          state_nxt = srt_tbl_pkg::S_RESP;
        end
      end
      srt_tbl_pkg::S_RESP: begin
        if (sts.out_free) begin
          state_nxt = srt_tbl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = srt_tbl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rsel = srt_tbl_pkg::RS_LO;
    in_stall = state_r != srt_tbl_pkg::S_IDLE;
    case (state_r)
      srt_tbl_pkg::S_IDLE: begin
        cmd.load = in_valid;
      end
      srt_tbl_pkg::S_DISP: begin
        case (sts.op)
          srt_tbl_pkg::OP_REMOVE_AT: begin
            cmd.lo_from_pos = sts.pos_ok;
            cmd.set_ok      = sts.pos_ok;
          end
          srt_tbl_pkg::OP_READ: begin
            cmd.rsel = srt_tbl_pkg::RS_POS;
          end
          default: begin
            cmd.rsel = srt_tbl_pkg::RS_LO;
          end
        endcase
      end
      srt_tbl_pkg::S_SRCH: begin
        // Once the window closes, fetch the word at the insertion point.
        cmd.rsel = sts.srch_open ? srt_tbl_pkg::RS_MID : srt_tbl_pkg::RS_LO;
      end
      srt_tbl_pkg::S_SCMP: begin
        cmd.srch_upd = 1'b1;
      end
      srt_tbl_pkg::S_EVAL: begin
        case (sts.op)
          srt_tbl_pkg::OP_INSERT: begin
            cmd.set_ok      = 1'b1;
            cmd.p_from_fill = 1'b1;
          end
          srt_tbl_pkg::OP_REMOVE_VAL: begin
            cmd.set_ok    = sts.hit;
            cmd.p_from_lo = sts.hit;
          end
          srt_tbl_pkg::OP_FIND: begin
            cmd.set_find = 1'b1;
          end
          default: begin
            cmd.set_ok = 1'b0;
          end
        endcase
      end
      srt_tbl_pkg::S_READ: begin
        cmd.set_read = 1'b1;
      end
      srt_tbl_pkg::S_IPRIME: begin
        cmd.rsel = srt_tbl_pkg::RS_PM1;
      end
      srt_tbl_pkg::S_ISHIFT: begin
        cmd.shift_up = 1'b1;
        cmd.rsel     = srt_tbl_pkg::RS_PM2;
      end
      srt_tbl_pkg::S_IWRITE: begin
        cmd.wr_new = 1'b1;
      end
      srt_tbl_pkg::S_DPRIME: begin
        cmd.rsel     = srt_tbl_pkg::RS_PP1;
        cmd.fill_dec = sts.pp1_end;
      end
      srt_tbl_pkg::S_DSHIFT: begin
        cmd.shift_down = 1'b1;
        cmd.rsel       = srt_tbl_pkg::RS_PP2;
        cmd.fill_dec   = sts.pp2_end;
      end
      srt_tbl_pkg::S_RESP: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/sorted_table.sv -----
// One item at a time: a read is addressed in S_DISP, captured in S_READ and sent to
// the output register from S_RESP once it is free. Search is binary: each step reads
// the middle entry through the table memory's read port in S_SRCH, then narrows in S_SCMP.
// Insert and remove shift entries singly; the next item is taken when the last leaves.
// Reset empties the table and the output register at once; there is no memory sweep.
module sorted_table #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [srt_tbl_pkg::OP_W-1:0]        in_op,
  input  logic [srt_tbl_pkg::VAL_W-1:0]       in_item_value,
  input  logic [srt_tbl_pkg::SLOT_W-1:0]      in_slot_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_ok,
  output logic [srt_tbl_pkg::VAL_W-1:0]       out_read_value,
  output logic                                out_found,
  output logic [srt_tbl_pkg::COUNT_W-1:0]     out_found_position,
  output logic [srt_tbl_pkg::COUNT_W-1:0]     out_entry_count
);

  srt_tbl_pkg::cmd_t cmd;
  srt_tbl_pkg::sts_t sts;

  srt_tbl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  srt_tbl_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_op             (in_op),
    .in_item_value     (in_item_value),
    .in_slot_index     (in_slot_index),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_ok            (out_ok),
    .out_read_value    (out_read_value),
    .out_found         (out_found),
    .out_found_position(out_found_position),
    .out_entry_count   (out_entry_count),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

// ----- rtl/srt_tbl_chk.sv -----
`include "sorted_table_assert.svh"

module srt_tbl_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_ok,
  input logic [srt_tbl_pkg::VAL_W-1:0]   out_read_value,
  input logic                            out_found,
  input logic [srt_tbl_pkg::COUNT_W-1:0] out_found_position
);

  // A result waiting on a stalled receiver keeps its payload.
  `ST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_value) && $stable(out_found_position), "stalled result item changed")

  // Each accepted item keeps the block busy for at least the next cycle.
  `ST_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "block took items on consecutive cycles")

  // A failed item reports no read data and no lookup result.
  `ST_ASSERT_NOW(a_fail_clean, out_valid && !out_ok, out_read_value == '0 && !out_found && out_found_position == '0, "failed item carries data")

  // Read data only ever comes from a successful read.
  `ST_ASSERT_NOW(a_data_needs_ok, out_valid && out_read_value != '0, out_ok, "read data without success")

endmodule

bind sorted_table srt_tbl_chk u_srt_tbl_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_ok            (out_ok),
  .out_read_value    (out_read_value),
  .out_found         (out_found),
  .out_found_position(out_found_position)
);

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OP_W = srt_tbl_pkg::OP_W;
  localparam int VAL_W = srt_tbl_pkg::VAL_W;
  localparam int SLOT_W = srt_tbl_pkg::SLOT_W;
  localparam int COUNT_W = srt_tbl_pkg::COUNT_W;
  localparam int TABLE_DEPTH = 64;
  localparam int MAX_WAIT = 13;
  localparam int HOLD_OFF = 400;
  localparam int HOLD_OFF_AT = 200;
  localparam int PAUSE_PHASE = 3;
  localparam int PHASE_ITEMS = 150;
  localparam int PHASE_COUNT = 7;
  localparam int DRAIN_CYCLES = 120;
  localparam int IDLE_LIMIT = 3000;
  localparam logic [OP_W-1:0] OP_FIRST_SPARE = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_CODE = 3'd7;

  typedef struct packed {
    logic               ok;
    logic [VAL_W-1:0]   read_value;
    logic               found;
    logic [COUNT_W-1:0] found_position;
    logic [COUNT_W-1:0] entry_count;
  } table_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    in_op = '0;
  logic [VAL_W-1:0]   in_item_value = '0;
  logic [SLOT_W-1:0]  in_slot_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_ok;
  logic [VAL_W-1:0]   out_read_value;
  logic               out_found;
  logic [COUNT_W-1:0] out_found_position;
  logic [COUNT_W-1:0] out_entry_count;

  sorted_table #(
    .CAPACITY(TABLE_DEPTH)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_item_value      (in_item_value),
    .in_slot_index      (in_slot_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ok             (out_ok),
    .out_read_value     (out_read_value),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count)
  );

  // Mirror of the ascending table, updated as each request is accepted.
  class table_scoreboard;
    logic [VAL_W-1:0] entries [TABLE_DEPTH];
    int unsigned      fill;
    table_result_t    awaited [$];
    int unsigned      errors;

    function int unsigned rank_of(logic [VAL_W-1:0] v);
      int unsigned i;
      i = 0;
      while (i < fill && entries[i] < v) i++;
      return i;
    endfunction

    function void drop_at(int unsigned idx);
      for (int unsigned i = idx; i + 1 < fill; i++) entries[i] = entries[i + 1];
      fill--;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [VAL_W-1:0] v,
                            logic [SLOT_W-1:0] slot);
      table_result_t want;
      int unsigned   idx;
      want = '0;
      case (op)
        srt_tbl_pkg::OP_INSERT: begin
          if (fill < TABLE_DEPTH) begin
            idx = rank_of(v);
            for (int unsigned i = fill; i > idx; i--) entries[i] = entries[i - 1];
            entries[idx] = v;
            fill++;
            want.ok = 1'b1;
          end
        end
        srt_tbl_pkg::OP_REMOVE_VAL: begin
          idx = rank_of(v);
          if (idx < fill && entries[idx] == v) begin
            drop_at(idx);
            want.ok = 1'b1;
          end
        end
        srt_tbl_pkg::OP_REMOVE_AT: begin
          if (slot >= 1 && slot <= fill) begin
            drop_at(slot - 1);
            want.ok = 1'b1;
          end
        end
        srt_tbl_pkg::OP_READ: begin
          if (slot >= 1 && slot <= fill) begin
            want.read_value = entries[slot - 1];
            want.ok = 1'b1;
          end
        end
        srt_tbl_pkg::OP_FIND: begin
          idx = rank_of(v);
          want.found = (idx < fill && entries[idx] == v);
          want.found_position = COUNT_W'(idx + 1);
          want.ok = 1'b1;
        end
        default: ;
      endcase
      want.entry_count = COUNT_W'(fill);
      awaited.push_back(want);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = awaited.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
        end
      end
    endfunction
  endclass

  table_scoreboard sb = new;
  int unsigned     sent_items = 0;
  int unsigned     idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] v,
                           input logic [SLOT_W-1:0] slot);
    int unsigned gap;
    // Every third stretch of 80 items goes out back to back.
    gap = ((sent_items / 80) % 3 == 2) ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_item_value <= v;
    in_slot_index <= slot;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, v, slot);
    sent_items++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Values are biased towards ones already held so that hits and duplicates are common.
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] pool [8];
    int unsigned      r;
    logic [VAL_W-1:0] held;
    pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0009};
    r = $urandom_range(0, 9);
    if (r < 3) return pool[$urandom_range(0, 7)];
    if (sb.fill > 0 && r < 7) begin
      held = sb.entries[$urandom_range(0, sb.fill - 1)];
      if (r < 6) return held;
      return $urandom_range(0, 1) ? held + 32'd1 : held - 32'd1;
    end
    return $urandom;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 9) == 0) return SLOT_W'($urandom_range(0, 127));
    return SLOT_W'($urandom_range(0, sb.fill + 1));
  endfunction

  // A filling phase leans on inserts; a draining one leans on removals.
  task automatic run_random(input int count, input bit filling);
    int unsigned     r;
    logic [OP_W-1:0] op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < (filling ? 65 : 10))      op = srt_tbl_pkg::OP_INSERT;
      else if (r < (filling ? 73 : 40)) op = srt_tbl_pkg::OP_REMOVE_VAL;
      else if (r < (filling ? 81 : 70)) op = srt_tbl_pkg::OP_REMOVE_AT;
      else if (r < (filling ? 88 : 82)) op = srt_tbl_pkg::OP_READ;
      else if (r < 97)                  op = srt_tbl_pkg::OP_FIND;
      else op = OP_W'($urandom_range(OP_FIRST_SPARE, OP_LAST_CODE));
      send_item(op, pick_value(), pick_slot());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: misses, out-of-range positions and the spare op codes.
    send_item(srt_tbl_pkg::OP_FIND, 32'd5, 7'd0);
    send_item(srt_tbl_pkg::OP_REMOVE_VAL, 32'd5, 7'd0);
    send_item(srt_tbl_pkg::OP_READ, 32'd0, 7'd0);
    send_item(srt_tbl_pkg::OP_READ, 32'd0, 7'd1);
    send_item(srt_tbl_pkg::OP_REMOVE_AT, 32'd0, 7'd1);
    for (int k = OP_FIRST_SPARE; k <= OP_LAST_CODE; k++)
      send_item(k[OP_W-1:0], 32'hFFFF_FFFF, 7'h7F);

    // Extremes and equal values, each new one ahead of its equals.
    send_item(srt_tbl_pkg::OP_INSERT, 32'hFFFF_FFFF, 7'd0);
    send_item(srt_tbl_pkg::OP_INSERT, 32'h0000_0000, 7'd0);
    send_item(srt_tbl_pkg::OP_INSERT, 32'd7, 7'd0);
    send_item(srt_tbl_pkg::OP_INSERT, 32'd7, 7'd0);
    send_item(srt_tbl_pkg::OP_INSERT, 32'h0000_0000, 7'd0);
    send_item(srt_tbl_pkg::OP_FIND, 32'd7, 7'd0);
    send_item(srt_tbl_pkg::OP_FIND, 32'd8, 7'd0);
    send_item(srt_tbl_pkg::OP_FIND, 32'hFFFF_FFFF, 7'd0);
    send_item(srt_tbl_pkg::OP_FIND, 32'hFFFF_FFFE, 7'd0);
    send_item(srt_tbl_pkg::OP_READ, 32'd0, 7'd1);
    send_item(srt_tbl_pkg::OP_READ, 32'd0, 7'd5);
    send_item(srt_tbl_pkg::OP_READ, 32'd0, 7'd6);
    send_item(srt_tbl_pkg::OP_READ, 32'd0, 7'h7F);
    send_item(srt_tbl_pkg::OP_REMOVE_VAL, 32'd7, 7'd0);
    send_item(srt_tbl_pkg::OP_REMOVE_VAL, 32'd8, 7'd0);
    send_item(srt_tbl_pkg::OP_REMOVE_AT, 32'd0, 7'd0);
    send_item(srt_tbl_pkg::OP_REMOVE_AT, 32'd0, 7'd1);
    send_item(srt_tbl_pkg::OP_REMOVE_AT, 32'd0, 7'd3);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      run_random(PHASE_ITEMS, phase % 2 == 0);
      if (phase == PAUSE_PHASE) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off so that the block backs up.
  initial begin
    int unsigned   stall_cycles;
    int unsigned   taken;
    table_result_t got;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == HOLD_OFF_AT) stall_cycles = HOLD_OFF;
      else if ((taken / 70) % 3 == 1) stall_cycles = 0;
      else stall_cycles = $urandom_range(0, MAX_WAIT);
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      got = '{out_ok, out_read_value, out_found, out_found_position, out_entry_count};
      sb.check_result(got);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/srt_tbl_pkg.sv
rtl/srt_tbl_ram.sv
rtl/srt_tbl_dp.sv
rtl/srt_tbl_ctrl.sv
rtl/sorted_table.sv
rtl/srt_tbl_chk.sv
sim/tb_top.sv
